/* sv/css_pkg.sv */
// Shared types and constants of the context-switch sampler.
package css_pkg;

    localparam int ID_W      = 22;
    localparam int TIME_W    = 64;
    localparam int CPU_W     = 3;
    localparam int CPU_NUM   = 8;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    // event kinds
    localparam logic OP_SWITCH = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // sample kinds
    localparam logic [KIND_W-1:0] KIND_RESUME       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLUSH        = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INTERMEDIATE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PROC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd2;

    localparam logic [TIME_W-1:0] DEFAULT_INTERVAL = 64'd1000000;

    typedef struct packed {
        logic              opcode;
        logic [CPU_W-1:0]  cpu;
        logic [TIME_W-1:0] now_time;
        logic [ID_W-1:0]   current_thread;
        logic [ID_W-1:0]   current_process;
        logic [ID_W-1:0]   incoming_thread;
        logic [ID_W-1:0]   incoming_process;
        logic [TIME_W-1:0] reading_zero;
        logic [TIME_W-1:0] reading_one;
        logic [TIME_W-1:0] reading_two;
        logic [TIME_W-1:0] reading_three;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] sample_kind;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] duration;
        logic [ID_W-1:0]   process_id;
        logic [ID_W-1:0]   thread_id;
        logic [CPU_W-1:0]  sample_cpu;
        logic [TIME_W-1:0] count_zero;
        logic [TIME_W-1:0] count_one;
        logic [TIME_W-1:0] count_two;
        logic [TIME_W-1:0] count_three;
    } out_item_t;

    // one entry of the thread table
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   thread;
        logic [TIME_W-1:0] start;
    } slot_entry_t;

    // sequencer requests to the table
    typedef struct packed {
        logic scan_start;
        logic wr_en;
    } css_req_t;

    // table status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic hit_a;
        logic hit_b;
        logic free_ok;
    } css_stat_t;

endpackage

/* sv/css_table.sv */
// Thread table memory with clearing pass and sequential lookup scan.
module css_table
    import css_pkg::*;
#(
    parameter int THREAD_SLOTS = 64,
    localparam int IW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  css_req_t             req,
    input  logic [ID_W-1:0]      key_a,
    input  logic [ID_W-1:0]      key_b,
    input  logic [IW-1:0]        wr_idx,
    input  slot_entry_t          wr_entry,
    output css_stat_t            stat,
    output logic [IW-1:0]        idx_a,
    output logic [IW-1:0]        idx_b,
    output logic [IW-1:0]        idx_free,
    output logic [TIME_W-1:0]    start_a
);

    localparam logic [IW-1:0] LAST = IW'(THREAD_SLOTS - 1);

    slot_entry_t slot_mem [THREAD_SLOTS];
    slot_entry_t rdata_reg;

    logic              clr_reg, clr_next;
    logic [IW-1:0]     clr_idx_reg, clr_idx_next;
    logic              scan_reg, scan_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    logic              chk_reg, chk_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic              chk_last_reg, chk_last_next;
    logic              done_reg, done_next;
    logic              hit_a_reg, hit_a_next;
    logic              hit_b_reg, hit_b_next;
    logic              free_reg, free_next;
    logic [IW-1:0]     idx_a_reg, idx_a_next;
    logic [IW-1:0]     idx_b_reg, idx_b_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [TIME_W-1:0] start_a_reg, start_a_next;

    logic              mem_we;
    logic [IW-1:0]     mem_widx;
    slot_entry_t       mem_wdata;

    // clearing pass has priority; the sequencer writes only when not busy
    always_comb
    begin
        mem_we    = clr_reg | req.wr_en;
        mem_widx  = clr_reg ? clr_idx_reg : wr_idx;
        mem_wdata = wr_entry;
        if (clr_reg)
        begin
            mem_wdata = '0;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_widx] <= mem_wdata;
        end
        if (scan_reg)
        begin
            rdata_reg <= slot_mem[rd_idx_reg];
        end
    end

    // clearing sweep, read counter and compare stage
    always_comb
    begin
        clr_next      = clr_reg;
        clr_idx_next  = clr_idx_reg;
        scan_next     = scan_reg;
        rd_idx_next   = rd_idx_reg;
        chk_next      = scan_reg;
        chk_idx_next  = rd_idx_reg;
        chk_last_next = (rd_idx_reg == LAST);
        done_next     = chk_reg & chk_last_reg;
        hit_a_next    = hit_a_reg;
        hit_b_next    = hit_b_reg;
        free_next     = free_reg;
        idx_a_next    = idx_a_reg;
        idx_b_next    = idx_b_reg;
        free_idx_next = free_idx_reg;
        start_a_next  = start_a_reg;

        if (clr_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST)
            begin
                clr_next = 1'b0;
            end
        end

        if (req.scan_start)
        begin
            scan_next   = 1'b1;
            rd_idx_next = '0;
            hit_a_next  = 1'b0;
            hit_b_next  = 1'b0;
            free_next   = 1'b0;
        end
        else if (scan_reg)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
            if (rd_idx_reg == LAST)
            begin
                scan_next = 1'b0;
            end
        end

        // threads are unique in the table, so the first hit is the only one
        if (chk_reg)
        begin
            if (rdata_reg.valid && rdata_reg.thread == key_a && !hit_a_reg)
            begin
                hit_a_next   = 1'b1;
                idx_a_next   = chk_idx_reg;
                start_a_next = rdata_reg.start;
            end
            if (rdata_reg.valid && rdata_reg.thread == key_b && !hit_b_reg)
            begin
                hit_b_next = 1'b1;
                idx_b_next = chk_idx_reg;
            end
            if (!rdata_reg.valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = chk_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_idx_reg  <= '0;
            scan_reg     <= 1'b0;
            rd_idx_reg   <= '0;
            chk_reg      <= 1'b0;
            chk_last_reg <= 1'b0;
            done_reg     <= 1'b0;
            hit_a_reg    <= 1'b0;
            hit_b_reg    <= 1'b0;
            free_reg     <= 1'b0;
        end
        else
        begin
            clr_reg      <= clr_next;
            clr_idx_reg  <= clr_idx_next;
            scan_reg     <= scan_next;
            rd_idx_reg   <= rd_idx_next;
            chk_reg      <= chk_next;
            chk_last_reg <= chk_last_next;
            done_reg     <= done_next;
            hit_a_reg    <= hit_a_next;
            hit_b_reg    <= hit_b_next;
            free_reg     <= free_next;
        end
    end

    // scan results, no reset needed
    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        idx_a_reg    <= idx_a_next;
        idx_b_reg    <= idx_b_next;
        free_idx_reg <= free_idx_next;
        start_a_reg  <= start_a_next;
    end

    assign stat.busy    = clr_reg;
    assign stat.done    = done_reg;
    assign stat.hit_a   = hit_a_reg;
    assign stat.hit_b   = hit_b_reg;
    assign stat.free_ok = free_reg;
    assign idx_a        = idx_a_reg;
    assign idx_b        = idx_b_reg;
    assign idx_free     = free_idx_reg;
    assign start_a      = start_a_reg;

endmodule

/* sv/context_switch_sampler.sv */
// Top level of the context-switch sampler: config, sequencer and output register.
//
// Scheduler events (switch or timer tick) enter on in_valid/in_stall as one
// in_item; samples leave on out_valid/out_stall as one out_item. An item is
// taken at a clock edge with valid high and stall low. Each event gives zero
// or one sample.
// Configuration is written through cfg_write/cfg_index/cfg_data: index 0
// enable, 1 target process, 2 minimum interval. The user must write it only
// while idle; the block itself does not enforce this. Every enabled event
// scans the whole thread table through the table's single read port, one
// entry per cycle; no new event is taken before the last one is done. An
// event seen while disabled skips the scan and passes only the drop and put states.
// After reset the cpus are all stopped and a clearing pass over all
// THREAD_SLOTS entries empties the table; in_stall stays high during it.
// A finished sample waits in the output register while out_stall is high;
// the next event is accepted meanwhile, and its own sample waits until the
// register is free.
module context_switch_sampler
    import css_pkg::*;
#(
    parameter int CPU_COUNT     = 8,
    parameter int THREAD_SLOTS  = 64,
    parameter int COUNTER_SLOTS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item
);

    localparam int IW     = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int FLAG_N = (CPU_COUNT < CPU_NUM) ? CPU_COUNT : CPU_NUM;
    localparam int FW     = (FLAG_N > 1) ? $clog2(FLAG_N) : 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_CALC = 7'b0000100,
        ST_CMP  = 7'b0001000,
        ST_DROP = 7'b0010000,
        ST_PUT  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic              enable_reg;
    logic [ID_W-1:0]   target_reg;
    logic [TIME_W-1:0] interval_reg;
    logic [FLAG_N-1:0] stopped_reg, stopped_next;
    in_item_t          item_reg, item_next;
    logic              resume_reg, resume_next;
    logic              drop_reg, drop_next;
    logic              put_reg, put_next;
    logic              emit_reg, emit_next;
    logic [IW-1:0]     put_idx_reg, put_idx_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [TIME_W-1:0] dur_reg, dur_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    css_req_t          req;
    css_stat_t         stat;
    logic [IW-1:0]     idx_a, idx_b, idx_free;
    logic [TIME_W-1:0] start_a;
    slot_entry_t       wr_entry;
    logic [IW-1:0]     wr_idx;

    logic              accept;
    logic              has_flag;
    logic [FW-1:0]     flag_idx;
    logic              pass_cur, pass_in;
    logic              b_live, ge_min, avail;
    logic [IW-1:0]     low_idx;

    css_table #(
        .THREAD_SLOTS(THREAD_SLOTS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .key_a    (item_reg.current_thread),
        .key_b    (item_reg.incoming_thread),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry),
        .stat     (stat),
        .idx_a    (idx_a),
        .idx_b    (idx_b),
        .idx_free (idx_free),
        .start_a  (start_a)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            target_reg   <= '0;
            interval_reg <= DEFAULT_INTERVAL;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENABLE:       enable_reg   <= cfg_data[0];
                CFG_TARGET_PROC:  target_reg   <= cfg_data[ID_W-1:0];
                CFG_MIN_INTERVAL: interval_reg <= cfg_data[TIME_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_stall = !((state_reg == ST_IDLE) && !stat.busy);
    assign accept   = in_valid && !in_stall;
    assign has_flag = (32'(in_item.cpu) < CPU_COUNT);
    assign flag_idx = in_item.cpu[FW-1:0];

    // process filter
    assign pass_cur = (target_reg == '0) || (item_reg.current_process == target_reg);
    assign pass_in  = (target_reg == '0) || (item_reg.incoming_process == target_reg);

    // slot choice after the outgoing thread is dropped
    assign b_live  = stat.hit_b && (item_reg.incoming_thread != item_reg.current_thread);
    assign ge_min  = (dur_reg >= interval_reg);
    assign avail   = stat.free_ok || stat.hit_a;
    assign low_idx = (stat.free_ok && (!stat.hit_a || idx_free < idx_a)) ? idx_free : idx_a;

    // table write port: drop clears valid, put stores thread and start time
    always_comb
    begin
        wr_entry.valid  = 1'b1;
        wr_entry.thread = (item_reg.opcode == OP_TICK) ? item_reg.current_thread
                                                       : item_reg.incoming_thread;
        wr_entry.start  = item_reg.now_time;
        wr_idx          = put_idx_reg;
        if (state_reg == ST_DROP)
        begin
            wr_entry.valid = 1'b0;
            wr_idx         = idx_a;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        stopped_next   = stopped_reg;
        item_next      = item_reg;
        resume_next    = resume_reg;
        drop_next      = drop_reg;
        put_next       = put_reg;
        emit_next      = emit_reg;
        put_idx_next   = put_idx_reg;
        kind_next      = kind_reg;
        dur_next       = dur_reg;
        out_valid_next = out_valid_reg & out_stall;
        out_next       = out_reg;
        req.scan_start = 1'b0;
        req.wr_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_item;
                    if (!enable_reg)
                    begin
                        if (has_flag)
                        begin
                            stopped_next[flag_idx] = 1'b1;
                        end
                        drop_next  = 1'b0;
                        put_next   = 1'b0;
                        emit_next  = 1'b0;
                        state_next = ST_DROP;
                    end
                    else
                    begin
                        resume_next = has_flag && stopped_reg[flag_idx];
                        if (has_flag)
                        begin
                            stopped_next[flag_idx] = 1'b0;
                        end
                        req.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stat.done)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                dur_next   = item_reg.now_time - start_a;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                drop_next    = 1'b0;
                put_next     = 1'b0;
                emit_next    = 1'b0;
                kind_next    = KIND_RESUME;
                put_idx_next = low_idx;
                if (item_reg.opcode == OP_TICK)
                begin
                    if (resume_reg)
                    begin
                        emit_next    = 1'b1;
                        put_next     = pass_cur && avail;
                        put_idx_next = stat.hit_a ? idx_a : idx_free;
                    end
                    else if (stat.hit_a && ge_min)
                    begin
                        emit_next    = 1'b1;
                        kind_next    = KIND_INTERMEDIATE;
                        put_next     = 1'b1;
                        put_idx_next = idx_a;
                    end
                end
                else
                begin
                    drop_next = stat.hit_a;
                    put_next  = pass_in && (b_live || avail);
                    if (b_live)
                    begin
                        put_idx_next = idx_b;
                    end
                    if (resume_reg)
                    begin
                        emit_next = 1'b1;
                    end
                    else if (stat.hit_a)
                    begin
                        emit_next = 1'b1;
                        kind_next = KIND_FLUSH;
                    end
                end
                if (resume_reg)
                begin
                    dur_next = '0;
                end
                state_next = ST_DROP;
            end
            ST_DROP:
            begin
                req.wr_en  = drop_reg;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                req.wr_en  = put_reg;
                state_next = emit_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_next.sample_kind = kind_reg;
                    out_next.stamp       = item_reg.now_time;
                    out_next.duration    = dur_reg;
                    out_next.process_id  = item_reg.current_process;
                    out_next.thread_id   = item_reg.current_thread;
                    out_next.sample_cpu  = item_reg.cpu;
                    out_next.count_zero  = item_reg.reading_zero;
                    out_next.count_one   = (COUNTER_SLOTS > 1) ? item_reg.reading_one : '0;
                    out_next.count_two   = (COUNTER_SLOTS > 2) ? item_reg.reading_two : '0;
                    out_next.count_three = (COUNTER_SLOTS > 3) ? item_reg.reading_three
                                                               : '0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stopped_reg   <= '1;
            resume_reg    <= 1'b0;
            drop_reg      <= 1'b0;
            put_reg       <= 1'b0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stopped_reg   <= stopped_next;
            resume_reg    <= resume_next;
            drop_reg      <= drop_next;
            put_reg       <= put_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        put_idx_reg <= put_idx_next;
        kind_reg    <= kind_next;
        dur_reg     <= dur_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* sv/css_checker.sv */
// Port-level checker of the context-switch sampler and its bind.
module css_checker
    import css_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // a stalled sample holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled sample changed");

    // the block works on one event at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("event taken while busy");

    // only the three sample kinds appear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.sample_kind == KIND_RESUME)
                   || (out_item.sample_kind == KIND_FLUSH)
                   || (out_item.sample_kind == KIND_INTERMEDIATE))
        else $error("bad sample kind");

    // resume carries no elapsed time
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.sample_kind == KIND_RESUME |-> out_item.duration == '0)
        else $error("resume with nonzero duration");

endmodule

bind context_switch_sampler css_checker u_css_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
